// ===== rtl/fsts_pkg.sv =====
// Package for the fixed-step tick scheduler: payload and status types, datapath ops,
// register indexes, reset values, the wrap-tolerant difference function and a zero-interval guard.
// No dependencies; every other file of the block refers to it by scoped names.
package fsts_pkg;

  // Tick cap per input item
  localparam int unsigned MAX_TICKS_DEF = 63;

  // Reset values of the architectural state
  localparam logic [15:0] INTERVAL_RESET   = 16'd16;
  localparam logic [31:0] START_TIME_RESET = 32'h0000_0000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME       = 1'd1;

  // Wrap detection window and adjustment
  localparam logic [31:0] WRAP_LO  = 32'h0000_ffff;
  localparam logic [31:0] WRAP_HI  = 32'hffff_0000;
  localparam logic [31:0] WRAP_ADJ = 32'h000f_ffff;

  localparam logic [16:0] FRAC_ONE = 17'h1_0000;
  localparam logic [31:0] SAT32    = 32'hffff_ffff;

  // Divider step counts, minus one
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RESCALE_M1 = 5'd31;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FRAC_M1    = 5'd15;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        paused;
    logic [15:0] requested_interval;
  } fsts_in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] tick_number;
    logic [31:0] tick_time;
    logic [16:0] fraction;
    logic        lag_overflow;
    logic        last;
  } fsts_out_t;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PAUSE,
    OP_MEAS,
    OP_MUL,
    OP_NUM,
    OP_DIV_RESCALE,
    OP_RESCALE,
    OP_TICK,
    OP_FRAC,
    OP_SUMMARY
  } fsts_op_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tick_due;
    logic pend_nz;
    logic paused;
    logic out_free;
    logic div_done;
  } fsts_stat_t;

  // Absolute difference, shifting both values when they straddle the wrap point
  function automatic logic [31:0] wrap_diff(input logic [31:0] a, input logic [31:0] b);
    logic        near;
    logic [31:0] aa;
    logic [31:0] bb;
    near = ((a < WRAP_LO) && (b > WRAP_HI)) || ((b < WRAP_LO) && (a > WRAP_HI));
    aa   = near ? (a + WRAP_ADJ) : a;
    bb   = near ? (b + WRAP_ADJ) : b;
    return (aa > bb) ? (aa - bb) : (bb - aa);
  endfunction

  // Map a zero interval to one
  function automatic logic [15:0] safe_interval(input logic [15:0] v);
    return (v == 16'h0000) ? 16'h0001 : v;
  endfunction

endpackage

// ===== rtl/fsts_div.sv =====
// Iterative restoring divider for the tick scheduler, one quotient bit per cycle.
// Serves both the interval rescale and the Q0.16 fraction. Uses fsts_pkg.
module fsts_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fsts_pkg::DIV_CNT_W-1:0]  steps_m1,
  input  logic [16:0]                     rem_init,
  input  logic [31:0]                     low_init,
  input  logic [16:0]                     den,
  output logic [31:0]                     quo,
  output logic                            done
);

  logic                           busy_r;
  logic                           done_r;
  logic [fsts_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [16:0]                    rem_r;
  logic [31:0]                    low_r;
  logic [16:0]                    den_r;
  logic [31:0]                    quo_r;
  logic [17:0]                    rem_sh;
  logic [17:0]                    rem_sub;
  logic                           qbit;

  // One restoring step: shift in the next dividend bit, subtract when it fits
  assign rem_sh  = {rem_r, low_r[31]};
  assign qbit    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps_m1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      low_r <= low_init;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= qbit ? rem_sub[16:0] : rem_sh[16:0];
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], qbit};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== rtl/fsts_dp.sv =====
// Datapath of the tick scheduler: schedule state, rescale multiplier, shared divider
// and the output register. Driven by fsts_ctrl ops; uses fsts_pkg and fsts_div.
module fsts_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fsts_pkg::fsts_op_t                  op,
  output fsts_pkg::fsts_stat_t                stat,
  input  fsts_pkg::fsts_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fsts_pkg::fsts_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fsts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Architectural state
  logic [15:0] cur_r;
  logic [15:0] pend_r;
  logic [31:0] ltt_r;
  logic [31:0] le_r;
  logic [31:0] tick_num_r;
  logic        paused_r;
  logic        out_valid_r;

  // Per-item working registers
  logic [31:0]           now_r;
  logic [47:0]           prod_r;
  logic [49:0]           num_r;
  logic                  sat_r;
  logic                  frac_sat_r;
  logic                  ovf_r;
  fsts_pkg::fsts_out_t   out_data_r;

  logic [31:0] wd_ltt;
  logic [31:0] ltt_step;
  logic [31:0] frac_x;
  logic [31:0] new_diff;
  logic [16:0] fraction;
  logic        tick_due;

  logic                           div_start;
  logic [fsts_pkg::DIV_CNT_W-1:0] div_steps_m1;
  logic [16:0]                    div_rem_init;
  logic [31:0]                    div_low_init;
  logic [16:0]                    div_den;
  logic [31:0]                    div_quo;
  logic                           div_done;

  assign wd_ltt   = fsts_pkg::wrap_diff(now_r, ltt_r);
  assign ltt_step = ltt_r + {16'h0000, cur_r};
  assign tick_due = (le_r >= {16'h0000, cur_r});
  assign frac_x   = paused_r ? le_r : wd_ltt;
  assign new_diff = sat_r ? fsts_pkg::SAT32 : div_quo;
  assign fraction = frac_sat_r ? fsts_pkg::FRAC_ONE : {1'b0, div_quo[15:0]};

  // Feed the shared divider: rescale uses the 50-bit numerator, fraction shifts in zeros
  always_comb begin
    div_start    = 1'b0;
    div_steps_m1 = fsts_pkg::DIV_STEPS_FRAC_M1;
    div_rem_init = {1'b0, frac_x[15:0]};
    div_low_init = 32'h0000_0000;
    div_den      = {1'b0, cur_r};
    if (op == fsts_pkg::OP_DIV_RESCALE) begin
      div_start    = 1'b1;
      div_steps_m1 = fsts_pkg::DIV_STEPS_RESCALE_M1;
      div_rem_init = num_r[48:32];
      div_low_init = num_r[31:0];
      div_den      = {cur_r, 1'b0};
    end else if (op == fsts_pkg::OP_FRAC) begin
      div_start = 1'b1;
    end
  end

  fsts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps_m1 (div_steps_m1),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .den      (div_den),
    .quo      (div_quo),
    .done     (div_done)
  );

  // Schedule state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= fsts_pkg::INTERVAL_RESET;
      pend_r      <= '0;
      ltt_r       <= fsts_pkg::START_TIME_RESET;
      le_r        <= '0;
      tick_num_r  <= '0;
      paused_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        fsts_pkg::OP_LATCH: begin
          paused_r <= in_data.paused;
          if (in_data.requested_interval != 16'h0000) begin
            pend_r <= (in_data.requested_interval == cur_r) ? 16'h0000
                                                            : in_data.requested_interval;
          end
        end
        fsts_pkg::OP_PAUSE: begin
          ltt_r <= now_r - le_r;
        end
        fsts_pkg::OP_MEAS: begin
          le_r <= wd_ltt;
        end
        fsts_pkg::OP_RESCALE: begin
          le_r   <= new_diff;
          ltt_r  <= now_r - new_diff;
          cur_r  <= pend_r;
          pend_r <= '0;
        end
        fsts_pkg::OP_TICK: begin
          out_valid_r <= 1'b1;
          ltt_r       <= ltt_step;
          tick_num_r  <= tick_num_r + 32'd1;
          le_r        <= fsts_pkg::wrap_diff(now_r, ltt_step);
        end
        fsts_pkg::OP_SUMMARY: begin
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
      // Configuration writes must arrive only while idle; this block does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          fsts_pkg::CFG_INITIAL_INTERVAL: begin
            cur_r  <= fsts_pkg::safe_interval(cfg_wdata[15:0]);
            pend_r <= '0;
          end
          fsts_pkg::CFG_START_TIME: begin
            ltt_r <= cfg_wdata;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers and output beat
  always_ff @(posedge clk) begin
    unique case (op)
      fsts_pkg::OP_LATCH: begin
        now_r <= in_data.now_ms;
      end
      fsts_pkg::OP_MUL: begin
        prod_r <= le_r * pend_r;
      end
      fsts_pkg::OP_NUM: begin
        num_r <= {1'b0, prod_r, 1'b0} + {34'h0, cur_r};
      end
      fsts_pkg::OP_DIV_RESCALE: begin
        sat_r <= (num_r[49:32] >= {1'b0, cur_r, 1'b0});
      end
      fsts_pkg::OP_FRAC: begin
        frac_sat_r <= (frac_x >= {16'h0000, cur_r});
        ovf_r      <= !paused_r && tick_due;
      end
      fsts_pkg::OP_TICK: begin
        out_data_r.kind         <= fsts_pkg::KIND_TICK;
        out_data_r.tick_number  <= tick_num_r;
        out_data_r.tick_time    <= now_r;
        out_data_r.fraction     <= '0;
        out_data_r.lag_overflow <= 1'b0;
        out_data_r.last         <= 1'b0;
      end
      fsts_pkg::OP_SUMMARY: begin
        out_data_r.kind         <= fsts_pkg::KIND_SUMMARY;
        out_data_r.tick_number  <= tick_num_r;
        out_data_r.tick_time    <= now_r;
        out_data_r.fraction     <= fraction;
        out_data_r.lag_overflow <= ovf_r;
        out_data_r.last         <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.tick_due = tick_due;
  assign stat.pend_nz  = (pend_r != 16'h0000);
  assign stat.paused   = paused_r;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.div_done = div_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/fsts_ctrl.sv =====
// Controller of the tick scheduler: sequences measure, rescale, tick emission and
// summary, and counts ticks against the cap. Uses fsts_pkg; drives fsts_dp.
module fsts_ctrl #(
  parameter int unsigned MAX_TICKS = fsts_pkg::MAX_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsts_pkg::fsts_stat_t  stat,
  output fsts_pkg::fsts_op_t    op
);

  localparam int unsigned TCNT_W = $clog2(MAX_TICKS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CHKPEND,
    S_NUM,
    S_DIVGO,
    S_DIVWAIT,
    S_TICK,
    S_FRAC,
    S_FRACWAIT,
    S_SUM
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [TCNT_W-1:0]   tcnt_r;
  logic [TCNT_W-1:0]   tcnt_nxt;
  logic                cap_ok;

  assign cap_ok = (tcnt_r < TCNT_W'(MAX_TICKS));

  // Next state and datapath op
  always_comb begin
    state_nxt = state_r;
    tcnt_nxt  = tcnt_r;
    op        = fsts_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = fsts_pkg::OP_LATCH;
          tcnt_nxt  = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.paused) begin
          op        = fsts_pkg::OP_PAUSE;
          state_nxt = S_FRAC;
        end else begin
          op        = fsts_pkg::OP_MEAS;
          state_nxt = S_CHKPEND;
        end
      end
      S_CHKPEND: begin
        if (stat.pend_nz) begin
          op        = fsts_pkg::OP_MUL;
          state_nxt = S_NUM;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_NUM: begin
        op        = fsts_pkg::OP_NUM;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        op        = fsts_pkg::OP_DIV_RESCALE;
        state_nxt = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (stat.div_done) begin
          op        = fsts_pkg::OP_RESCALE;
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        // Emit one tick per free output slot until none is due or the cap is hit
        if (stat.tick_due && cap_ok) begin
          if (stat.out_free) begin
            op       = fsts_pkg::OP_TICK;
            tcnt_nxt = tcnt_r + 1'b1;
          end
        end else begin
          state_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        op        = fsts_pkg::OP_FRAC;
        state_nxt = S_FRACWAIT;
      end
      S_FRACWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (stat.out_free) begin
          op        = fsts_pkg::OP_SUMMARY;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and tick count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tcnt_r  <= tcnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/fixed_step_tick_scheduler_unit.sv =====
// Top level of the fixed-step tick scheduler: controller plus datapath.
// Depends on fsts_pkg, fsts_ctrl, fsts_dp and fsts_div.
//
// Usage:
//   Input beats (in_valid/in_ready, in_data) carry a millisecond timestamp, a pause
//   flag and an optional interval request. For each input beat the block sends zero
//   or more tick beats (kind 0), one per whole interval elapsed, up to
//   MAX_TICKS_PER_ITEM, then one summary beat (kind 1, last 1) with the Q0.16
//   fraction and the lag-overflow flag on out_valid/out_ready, out_data.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) load the interval or the
//   last tick time. Issue them only while the block is idle; it does not check.
// Timing:
//   One item at a time. An interval change adds the 50-by-17-bit rescale division,
//   one quotient bit per cycle; the Q0.16 fraction takes a second divider run.
//   Ticks leave at one beat per cycle while out_ready holds.
// Reset and stall:
//   Synchronous active-low reset loads interval 16, last tick time 0, counter 0.
//   A stalled receiver holds the output register; the block waits for the slot to
//   drain, and takes the next input beat while the summary is still waiting.
module fixed_step_tick_scheduler_unit #(
  parameter int unsigned MAX_TICKS_PER_ITEM = fsts_pkg::MAX_TICKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fsts_pkg::fsts_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fsts_pkg::fsts_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [fsts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  fsts_pkg::fsts_op_t   op;
  fsts_pkg::fsts_stat_t stat;

  fsts_ctrl #(
    .MAX_TICKS (MAX_TICKS_PER_ITEM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  fsts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== rtl/fsts_checker.sv =====
// Port-level checker for the tick scheduler, attached to the top level by bind.
// Depends on fsts_pkg and fixed_step_tick_scheduler_unit.
module fsts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input fsts_pkg::fsts_out_t  out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: no input beat in the cycle after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Only the summary closes an item
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == out_data.kind))
    else $error("last flag does not match beat kind");

  // Tick beats carry no fraction and no overflow
  a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == fsts_pkg::KIND_TICK)
      |-> (out_data.fraction == '0) && !out_data.lag_overflow)
    else $error("tick beat carries summary fields");

  // Summary fraction never exceeds 1.0
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == fsts_pkg::KIND_SUMMARY)
      |-> (out_data.fraction <= fsts_pkg::FRAC_ONE))
    else $error("summary fraction above 1.0");

endmodule

bind fixed_step_tick_scheduler_unit fsts_checker u_fsts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
